FILE: rtl/lrupr_pkg.sv
// lrupr_pkg: shared sizes and types of the lru page replacement block
// used by lrupr_slots and lru_page_replacement; no dependencies
`timescale 1ns / 1ps

package lrupr_pkg;

	localparam int MAX_PAGES     = 64;
	localparam int WORKING_SET   = 4;
	localparam int AGE_BITS      = 16;
	localparam int PAGE_BITS     = $clog2(MAX_PAGES);
	localparam int SLOT_BITS     = $clog2(WORKING_SET);
	localparam int PAGE_NUM_BITS = 7;
	localparam int FRAME_BITS    = 12;

	// slot lookup for the page under service
	typedef struct packed {
		logic                 found;
		logic [SLOT_BITS-1:0] hit_slot;
		logic [SLOT_BITS-1:0] victim_slot;
		logic                 victim_occupied;
		logic [PAGE_BITS-1:0] victim_page;
	} slot_lookup_t;

	// slot update for one request
	typedef struct packed {
		logic                 en;
		logic                 keep;
		logic                 load;
		logic [SLOT_BITS-1:0] slot;
	} slot_cmd_t;

endpackage

FILE: rtl/lru_page_replacement.sv
// lru_page_replacement: top level, request handshake, page table memory, valid bits
// depends on lrupr_pkg and lrupr_slots
`timescale 1ns / 1ps

// Age-counter LRU page replacement over four frame slots. On accept the page
// table memory is read at the requested page; in the execute state the
// registered read data, the page valid bit and the four parallel slot
// compares settle the result, and for an in-range request the slot ages are
// updated and, on a miss, the page table and valid bits are written. A result
// register sits on the output, so the next request is taken while a result
// still waits; the block only holds a request in its execute state while that
// register is full and not being drained. Configuration writes are always ready.
// Page valid bits are flip-flops cleared by reset, so no clearing pass runs.
module lru_page_replacement
	import lrupr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [PAGE_NUM_BITS-1:0] page_number,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     hit,
	output logic [SLOT_BITS-1:0]     slot_used,
	output logic [FRAME_BITS-1:0]    frame,
	output logic                     evicted,
	output logic [PAGE_BITS-1:0]     evicted_page,
	output logic [7:0]               owner_id,
	output logic                     request_error,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               cfg_index,
	input  logic [31:0]              cfg_data
);

	localparam logic [1:0] REG_BASE_FRAME = 2'd0;
	localparam logic [1:0] REG_PROCESS_ID = 2'd1;
	localparam logic [1:0] REG_PAGE_COUNT = 2'd2;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	localparam logic [PAGE_NUM_BITS-1:0] PAGE_LIMIT = PAGE_NUM_BITS'(MAX_PAGES);

	logic [FRAME_BITS-1:0]    base_frame_q;
	logic [7:0]               process_id_q;
	logic [PAGE_NUM_BITS-1:0] page_count_q;

	logic                     state_q;
	logic                     err_s1;
	logic [PAGE_BITS-1:0]     pg_s1;
	logic [FRAME_BITS-1:0]    ftab_rd_s1;
	logic [FRAME_BITS-1:0]    ftab_mem [MAX_PAGES];
	logic [MAX_PAGES-1:0]     pvalid_q;

	logic                     out_valid_q;
	logic                     in_fire;
	logic                     out_free;
	logic                     commit;
	logic                     is_hit;
	logic [PAGE_NUM_BITS-1:0] limit;
	logic [PAGE_NUM_BITS-1:0] req_m1;
	logic                     req_err;
	logic [FRAME_BITS-1:0]    new_frame;
	slot_lookup_t             lookup;
	slot_cmd_t                cmd;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;
	assign commit    = (state_q == ST_EXEC) && out_free;

	// range check of the incoming request
	assign limit   = (page_count_q > PAGE_LIMIT) ? PAGE_LIMIT : page_count_q;
	assign req_err = (page_number == '0) || (page_number > limit);
	assign req_m1  = page_number - 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_frame_q <= '0;
			process_id_q <= '0;
			page_count_q <= PAGE_NUM_BITS'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BASE_FRAME: base_frame_q <= cfg_data[FRAME_BITS-1:0];
				REG_PROCESS_ID: process_id_q <= cfg_data[7:0];
				REG_PAGE_COUNT: page_count_q <= cfg_data[PAGE_NUM_BITS-1:0];
				default: ;
			endcase
		end
	end

	// sequencer: accept, then execute and write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_fire) state_q <= ST_EXEC;
				ST_EXEC: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			err_s1 <= req_err;
			pg_s1  <= req_m1[PAGE_BITS-1:0];
		end
	end

	// slot state
	assign is_hit    = pvalid_q[pg_s1];
	assign new_frame = base_frame_q + FRAME_BITS'(lookup.victim_slot);

	always_comb begin
		cmd.en   = commit && !err_s1;
		cmd.keep = is_hit ? lookup.found : 1'b1;
		cmd.load = !is_hit;
		cmd.slot = is_hit ? lookup.hit_slot : lookup.victim_slot;
	end

	lrupr_slots u_slots (
		.clk    (clk),
		.arst_n (arst_n),
		.pg     (pg_s1),
		.cmd    (cmd),
		.lookup (lookup)
	);

	// page table memory, read on accept, written on a load
	always_ff @(posedge clk) begin
		if (cmd.en && !is_hit) begin
			ftab_mem[pg_s1] <= new_frame;
		end
		if (in_fire) begin
			ftab_rd_s1 <= ftab_mem[req_m1[PAGE_BITS-1:0]];
		end
	end

	// page valid bits: drop the evicted page, then mark the loaded one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvalid_q <= '0;
		end else if (cmd.en && !is_hit) begin
			if (lookup.victim_occupied) begin
				pvalid_q[lookup.victim_page] <= 1'b0;
			end
			pvalid_q[pg_s1] <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			request_error <= err_s1;
			if (err_s1) begin
				hit          <= 1'b0;
				slot_used    <= '0;
				frame        <= '0;
				evicted      <= 1'b0;
				evicted_page <= '0;
				owner_id     <= '0;
			end else if (is_hit) begin
				hit          <= 1'b1;
				slot_used    <= lookup.hit_slot;
				frame        <= ftab_rd_s1;
				evicted      <= 1'b0;
				evicted_page <= '0;
				owner_id     <= '0;
			end else begin
				hit          <= 1'b0;
				slot_used    <= lookup.victim_slot;
				frame        <= new_frame;
				evicted      <= lookup.victim_occupied;
				evicted_page <= lookup.victim_occupied ? lookup.victim_page : '0;
				owner_id     <= process_id_q;
			end
		end
	end

`ifndef SYNTHESIS
	a_fire_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == ST_EXEC)
		else $error("accepted request did not enter execute");

	a_load_marks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.en && !is_hit) |=> pvalid_q[$past(pg_s1)])
		else $error("loaded page not marked valid");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && request_error) |-> (!hit && !evicted && owner_id == '0))
		else $error("error result carries data");

	a_evict_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && evicted) |-> !hit)
		else $error("eviction reported on a hit");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && state_q == ST_EXEC) |=> $stable(frame))
		else $error("waiting result overwritten");
`endif

endmodule

FILE: rtl/lrupr_slots.sv
// lrupr_slots: working-set slot registers, hit search, victim choice and ageing
// depends on lrupr_pkg
`timescale 1ns / 1ps

module lrupr_slots
	import lrupr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [PAGE_BITS-1:0] pg,
	input  slot_cmd_t            cmd,
	output slot_lookup_t         lookup
);

	localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

	logic [PAGE_BITS-1:0] page_q [WORKING_SET];
	logic [AGE_BITS-1:0]  age_q  [WORKING_SET];
	logic [WORKING_SET-1:0] occ_q;

	// hit search and victim choice
	always_comb begin
		logic                have_empty;
		logic [AGE_BITS-1:0] oldest;
		// first occupied slot holding the page
		lookup.found    = 1'b0;
		lookup.hit_slot = '0;
		for (int s = WORKING_SET - 1; s >= 0; s--) begin
			if (occ_q[s] && page_q[s] == pg) begin
				lookup.found    = 1'b1;
				lookup.hit_slot = SLOT_BITS'(s);
			end
		end
		// victim: first empty slot, else the oldest with ties to the later slot
		have_empty         = 1'b0;
		oldest             = '0;
		lookup.victim_slot = '0;
		for (int s = 0; s < WORKING_SET; s++) begin
			if (!have_empty) begin
				if (!occ_q[s]) begin
					lookup.victim_slot = SLOT_BITS'(s);
					have_empty         = 1'b1;
				end else if (oldest <= age_q[s]) begin
					oldest             = age_q[s];
					lookup.victim_slot = SLOT_BITS'(s);
				end
			end
		end
		lookup.victim_occupied = occ_q[lookup.victim_slot];
		lookup.victim_page     = page_q[lookup.victim_slot];
	end

	// occupancy and ages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			for (int s = 0; s < WORKING_SET; s++) begin
				age_q[s] <= '0;
			end
		end else if (cmd.en) begin
			for (int s = 0; s < WORKING_SET; s++) begin
				if (cmd.keep && cmd.slot == SLOT_BITS'(s)) begin
					age_q[s] <= '0;
					if (cmd.load) begin
						occ_q[s] <= 1'b1;
					end
				end else if (occ_q[s] && age_q[s] != AGE_MAX) begin
					age_q[s] <= age_q[s] + 1'b1;
				end
			end
		end
	end

	// resident page of each slot
	always_ff @(posedge clk) begin
		if (cmd.en && cmd.load) begin
			page_q[cmd.slot] <= pg;
		end
	end

endmodule

FILE: tb/lru_page_replacement_tb.sv
// lru_page_replacement_tb: self-checking bench for the age-counter lru page replacement block
// depends on lrupr_pkg and lru_page_replacement; predicts every result and checks it field by field
`timescale 1ns / 1ps

module lru_page_replacement_tb;
	import lrupr_pkg::*;

	// register indexes of the configuration port
	localparam logic [1:0] REG_BASE_FRAME = 2'd0;
	localparam logic [1:0] REG_PROCESS_ID = 2'd1;
	localparam logic [1:0] REG_PAGE_COUNT = 2'd2;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		logic                  hit;
		logic [SLOT_BITS-1:0]  slot_used;
		logic [FRAME_BITS-1:0] frame;
		logic                  evicted;
		logic [PAGE_BITS-1:0]  evicted_page;
		logic [7:0]            owner_id;
		logic                  request_error;
	} page_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [PAGE_NUM_BITS-1:0] page_number;
	logic                     out_valid;
	logic                     out_ready;
	logic                     hit;
	logic [SLOT_BITS-1:0]     slot_used;
	logic [FRAME_BITS-1:0]    frame;
	logic                     evicted;
	logic [PAGE_BITS-1:0]     evicted_page;
	logic [7:0]               owner_id;
	logic                     request_error;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [1:0]               cfg_index;
	logic [31:0]              cfg_data;

	// predictor state
	logic [FRAME_BITS-1:0]    base_frame_reg;
	logic [7:0]               process_id_reg;
	logic [6:0]               page_count_reg;
	logic                     page_resident [MAX_PAGES];
	logic [FRAME_BITS-1:0]    page_frame    [MAX_PAGES];
	logic [PAGE_BITS-1:0]     slot_page     [WORKING_SET];
	logic                     slot_busy     [WORKING_SET];
	logic [AGE_BITS-1:0]      slot_age      [WORKING_SET];

	page_result_t             pending_results [$];

	// bench control and statistics
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	logic [6:0] cur_page_count = 7'd1;
	int error_count = 0;
	int checked_count = 0;
	int request_count = 0;
	int hit_count = 0;
	int load_count = 0;
	int evict_count = 0;
	int reject_count = 0;
	int reg_write_count = 0;

	lru_page_replacement dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.page_number  (page_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.slot_used    (slot_used),
		.frame        (frame),
		.evicted      (evicted),
		.evicted_page (evicted_page),
		.owner_id     (owner_id),
		.request_error(request_error),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	// every occupied slot but the kept one ages, saturating
	function automatic void age_other_slots(input int keep, input bit have_keep);
		for (int s = 0; s < WORKING_SET; s++) begin
			if (!(have_keep && s == keep) && slot_busy[s] && slot_age[s] != '1)
				slot_age[s] = slot_age[s] + 1'b1;
		end
	endfunction

	function automatic page_result_t serve_request(input logic [PAGE_NUM_BITS-1:0] req);
		page_result_t        r;
		int                  lim;
		int                  pg;
		int                  victim;
		bit                  found;
		bit                  empty_found;
		logic [AGE_BITS-1:0] oldest;
		r = '0;
		lim = (int'(page_count_reg) < MAX_PAGES) ? int'(page_count_reg) : MAX_PAGES;
		// out of range request leaves everything alone
		if (req == 0 || int'(req) > lim) begin
			r.request_error = 1'b1;
			return r;
		end
		pg = int'(req) - 1;
		victim = 0;
		// resident page: refresh its slot
		if (page_resident[pg]) begin
			found = 1'b0;
			for (int s = 0; s < WORKING_SET; s++) begin
				if (!found && slot_busy[s] && slot_page[s] == PAGE_BITS'(pg)) begin
					victim = s;
					found = 1'b1;
				end
			end
			age_other_slots(victim, found);
			if (found)
				slot_age[victim] = '0;
			r.hit = 1'b1;
			r.slot_used = SLOT_BITS'(victim);
			r.frame = page_frame[pg];
			return r;
		end
		// miss: first empty slot, else oldest with ties to the later slot
		oldest = '0;
		empty_found = 1'b0;
		for (int s = 0; s < WORKING_SET; s++) begin
			if (!empty_found) begin
				if (!slot_busy[s]) begin
					victim = s;
					empty_found = 1'b1;
				end else if (oldest <= slot_age[s]) begin
					oldest = slot_age[s];
					victim = s;
				end
			end
		end
		age_other_slots(victim, 1'b1);
		if (slot_busy[victim]) begin
			page_resident[slot_page[victim]] = 1'b0;
			r.evicted = 1'b1;
			r.evicted_page = slot_page[victim];
		end
		slot_page[victim] = PAGE_BITS'(pg);
		slot_busy[victim] = 1'b1;
		slot_age[victim] = '0;
		page_resident[pg] = 1'b1;
		page_frame[pg] = base_frame_reg + FRAME_BITS'(victim);
		r.slot_used = SLOT_BITS'(victim);
		r.frame = page_frame[pg];
		r.owner_id = process_id_reg;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// checking
	// ---------------------------------------------------------------

	task automatic report_mismatch(input string what, input int got, input int want);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("mismatch in %s at result %0d (t=%0t): got %0d, want %0d",
				what, checked_count, $realtime, got, want);
	endtask

	// config writes, result checks and predictions, all on the same edge
	always @(posedge clk) begin : scoreboard
		page_result_t got;
		page_result_t want;
		if (!arst_n) begin
			base_frame_reg = '0;
			process_id_reg = '0;
			page_count_reg = 7'd1;
			for (int p = 0; p < MAX_PAGES; p++) begin
				page_resident[p] = 1'b0;
				page_frame[p] = '0;
			end
			for (int s = 0; s < WORKING_SET; s++) begin
				slot_page[s] = '0;
				slot_busy[s] = 1'b0;
				slot_age[s] = '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				reg_write_count++;
				case (cfg_index)
					REG_BASE_FRAME: base_frame_reg = cfg_data[FRAME_BITS-1:0];
					REG_PROCESS_ID: process_id_reg = cfg_data[7:0];
					REG_PAGE_COUNT: page_count_reg = cfg_data[6:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got = '{hit, slot_used, frame, evicted, evicted_page, owner_id, request_error};
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result beat", 1, 0);
				end else begin
					want = pending_results.pop_front();
					if (got.hit !== want.hit)
						report_mismatch("hit", got.hit, want.hit);
					if (got.slot_used !== want.slot_used)
						report_mismatch("slot_used", got.slot_used, want.slot_used);
					if (got.frame !== want.frame)
						report_mismatch("frame", got.frame, want.frame);
					if (got.evicted !== want.evicted)
						report_mismatch("evicted", got.evicted, want.evicted);
					if (got.evicted_page !== want.evicted_page)
						report_mismatch("evicted_page", got.evicted_page, want.evicted_page);
					if (got.owner_id !== want.owner_id)
						report_mismatch("owner_id", got.owner_id, want.owner_id);
					if (got.request_error !== want.request_error)
						report_mismatch("request_error", got.request_error, want.request_error);
				end
				checked_count++;
			end
			if (in_valid && in_ready) begin
				want = serve_request(page_number);
				pending_results.push_back(want);
				request_count++;
				if (want.request_error)
					reject_count++;
				else if (want.hit)
					hit_count++;
				else
					load_count++;
				if (want.evicted)
					evict_count++;
			end
		end
	end

	// receiver: random stalls, or a long hold-off when asked
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results outstanding",
				STALL_LIMIT, pending_results.size());
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	// one request beat; valid stays high on return so back-to-back beats need no toggle
	task automatic send_page(input logic [PAGE_NUM_BITS-1:0] p);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		page_number <= p;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// all three registers, with junk in the unused upper bits
	task automatic set_config(input logic [11:0] base, input logic [7:0] pid, input logic [6:0] cnt);
		logic [31:0] word;
		word = $urandom;
		word[11:0] = base;
		write_reg(REG_BASE_FRAME, word);
		word = $urandom;
		word[7:0] = pid;
		write_reg(REG_PROCESS_ID, word);
		word = $urandom;
		word[6:0] = cnt;
		write_reg(REG_PAGE_COUNT, word);
		cfg_valid <= 1'b0;
		cur_page_count = cnt;
	endtask

	// stop offering, let every result drain, then allow for the pipeline
	task automatic end_phase();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mostly a small hot set for hits, some spread for misses, a few bad pages
	function automatic logic [PAGE_NUM_BITS-1:0] pick_page(input logic [6:0] count);
		int lim;
		int roll;
		int hot;
		lim = (int'(count) > MAX_PAGES) ? MAX_PAGES : int'(count);
		if (lim < 1)
			lim = 1;
		hot = (lim < 6) ? lim : 6;
		roll = $urandom_range(99);
		if (roll < 2)
			return '0;
		if (roll < 6)
			return PAGE_NUM_BITS'($urandom_range(127, lim + 1));
		if (roll < 55)
			return PAGE_NUM_BITS'($urandom_range(hot, 1));
		return PAGE_NUM_BITS'($urandom_range(lim, 1));
	endfunction

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// registers at reset value: only page 1 is legal
	task automatic test_reset_values();
		send_page(7'd1);
		send_page(7'd1);
		send_page(7'd2);
		send_page(7'd0);
		end_phase();
	endtask

	// field extremes, frame wrap, page count above the page limit, single page
	task automatic test_directed();
		set_config(12'd4093, 8'd255, 7'd64);
		send_page(7'd64);
		send_page(7'd2);
		send_page(7'd3);
		send_page(7'd1);
		send_page(7'd4);
		send_page(7'd64);
		send_page(7'd127);
		send_page(7'd65);
		send_page(7'd0);
		send_page(7'd1);
		end_phase();
		set_config(12'd4095, 8'd0, 7'd127);
		send_page(7'd64);
		send_page(7'd10);
		send_page(7'd65);
		send_page(7'd100);
		send_page(7'd11);
		end_phase();
		set_config(12'd0, 8'h3c, 7'd1);
		send_page(7'd1);
		send_page(7'd2);
		send_page(7'd0);
		end_phase();
	endtask

	// keep hitting one page while the other three age, then miss to evict the oldest
	task automatic test_age_order();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_config(12'd16, 8'ha5, 7'd8);
		for (int p = 5; p <= 8; p++)
			send_page(PAGE_NUM_BITS'(p));
		repeat (40) send_page(7'd5);
		send_page(7'd1);
		send_page(7'd2);
		send_page(7'd3);
		send_page(7'd5);
		send_page(7'd4);
		end_phase();
	endtask

	// receiver holds off while requests keep coming, so the block fills and stalls
	task automatic test_back_pressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_config(12'd200, 8'h77, 7'd12);
		hold_left <= HOLD_CYCLES;
		repeat (24) send_page(pick_page(cur_page_count));
		end_phase();
	endtask

	// three idling modes, each through four register settings
	task automatic test_random_traffic();
		logic [11:0] base;
		logic [7:0]  pid;
		logic [6:0]  cnt;
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 35;
					recv_idle_pct = 68;
				end
				1: begin
					send_idle_pct = 68;
					recv_idle_pct = 35;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int k = 0; k < 4; k++) begin
				case (k)
					0: begin
						base = 12'd0;
						pid = 8'd255;
						cnt = 7'd64;
					end
					1: begin
						base = 12'd4095;
						pid = 8'd0;
						cnt = 7'($urandom_range(12, 5));
					end
					2: begin
						base = 12'($urandom);
						pid = 8'($urandom);
						cnt = 7'd127;
					end
					default: begin
						base = 12'd4092;
						pid = 8'($urandom);
						cnt = 7'($urandom_range(8, 2));
					end
				endcase
				set_config(base, pid, cnt);
				repeat (130) send_page(pick_page(cur_page_count));
				end_phase();
			end
		end
	endtask

	// ---------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		page_number <= '0;
		out_ready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_BASE_FRAME;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_directed();
		test_age_order();
		test_back_pressure();
		test_random_traffic();

		repeat (8) @(posedge clk);
		$display("covered %0d requests: %0d hits, %0d loads, %0d evictions, %0d rejected",
			request_count, hit_count, load_count, evict_count, reject_count);
		$display("%0d results checked, %0d register writes, %0d mismatches",
			checked_count, reg_write_count, error_count);
		if (error_count == 0 && pending_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: sim.f
rtl/lrupr_pkg.sv
rtl/lrupr_slots.sv
rtl/lru_page_replacement.sv
tb/lru_page_replacement_tb.sv
